[rtl/pfr_pkg.sv]
// shared types, constants and helpers of the page fault replacement unit
package pfr_pkg;

  localparam int PAGES     = 256;
  localparam int FRAMES    = 64;
  localparam int PAGE_W    = 8;
  localparam int FRAME_W   = 6;
  localparam int NFR_W     = 7;
  localparam int FCNT_W    = 16;
  localparam int TOT_W     = 32;
  localparam int ACC_W     = 2;
  localparam int ACT_W     = 2;
  localparam int RND_W     = 16;
  localparam int RND_CW    = $clog2(RND_W);
  localparam int POL_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 7;
  localparam int PTE_W     = FCNT_W + FRAME_W + ACC_W;

  // page access levels
  localparam logic [ACC_W-1:0] ACC_NONE = 2'd0;
  localparam logic [ACC_W-1:0] ACC_READ = 2'd1;
  localparam logic [ACC_W-1:0] ACC_RW   = 2'd3;

  // disk commands
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WB    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GRANT = 2'd2;

  // replacement policies
  localparam logic [POL_W-1:0] POL_RANDOM = 2'd0;
  localparam logic [POL_W-1:0] POL_FIFO   = 2'd1;
  localparam logic [POL_W-1:0] POL_LEAST  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;

  typedef struct packed {
    logic [FCNT_W-1:0]  cnt;
    logic [FRAME_W-1:0] frame;
    logic [ACC_W-1:0]   acc;
  } pte_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

  function automatic logic [FCNT_W-1:0] sat_cnt(input logic [FCNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/pfr_ram.sv]
// generic single write, single registered read port ram
module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/pfr_rem.sv]
// iterative remainder unit, one dividend bit per cycle
module pfr_rem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pfr_pkg::RND_W-1:0]   dividend,
  input  logic [pfr_pkg::NFR_W-1:0]   divisor,
  output pfr_pkg::rem_stat_t          stat,
  output logic [pfr_pkg::FRAME_W-1:0] rem
);
  import pfr_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [RND_CW-1:0] cnt_r, cnt_nxt;
  logic [RND_W-1:0]  dvd_r, dvd_nxt;
  logic [NFR_W-1:0]  div_r, div_nxt;
  logic [FRAME_W-1:0] rem_r, rem_nxt;
  logic [NFR_W-1:0]  trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[RND_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so one subtract suffices
      if (trial >= div_r) begin
        rem_nxt = FRAME_W'(trial - div_r);
      end else begin
        rem_nxt = trial[FRAME_W-1:0];
      end
      dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == RND_CW'(RND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

[rtl/page_fault_replacement_unit.sv]
// top level: page fault sequencer, page and frame tables, counters, result register
// One page fault word is taken at a time. A write-permission grant or a fault served from a free
// frame goes from the lookup straight to its result word. An eviction first picks a victim frame:
// FIFO takes the pointer; random uses the 16-step remainder unit that reduces random_pick modulo
// frames_in_use; least-faults uses the scan that reads one frame owner and its fault count per
// cycle through the owner and page table memories. A writeback adds one result word. The next
// fault is accepted while the last result word still waits at the output. Page table entries
// carry valid bits, so no clearing pass follows reset.
module page_fault_replacement_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pfr_pkg::PAGE_W-1:0]    in_page,
  input  logic [pfr_pkg::RND_W-1:0]     in_random_pick,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfr_pkg::ACT_W-1:0]     out_action,
  output logic [pfr_pkg::PAGE_W-1:0]    out_target_page,
  output logic [pfr_pkg::FRAME_W-1:0]   out_target_frame,
  output logic                          out_last,
  output logic [pfr_pkg::TOT_W-1:0]     out_total_faults,
  output logic [pfr_pkg::TOT_W-1:0]     out_total_write_faults,
  output logic [pfr_pkg::TOT_W-1:0]     out_total_disk_reads,
  output logic [pfr_pkg::TOT_W-1:0]     out_total_disk_writes,
  input  logic                          cfg_we,
  input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfr_pkg::CFG_W-1:0]     cfg_data
);
  import pfr_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOOK    = 4'd1;
  localparam logic [3:0] S_REM     = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_OWN     = 4'd4;
  localparam logic [3:0] S_OWN_W   = 4'd5;
  localparam logic [3:0] S_VIC     = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;
  localparam logic [3:0] S_EMIT_WB = 4'd8;
  localparam logic [3:0] S_EMIT_RD = 4'd9;

  logic [3:0]         state_r, state_nxt;
  logic [POL_W-1:0]   policy_r, policy_nxt;
  logic [NFR_W-1:0]   frames_r, frames_nxt;
  logic [NFR_W-1:0]   free_r, free_nxt;
  logic [FRAME_W-1:0] fifo_r, fifo_nxt;
  logic [TOT_W-1:0]   faults_r, faults_nxt;
  logic [TOT_W-1:0]   wfaults_r, wfaults_nxt;
  logic [TOT_W-1:0]   reads_r, reads_nxt;
  logic [TOT_W-1:0]   writes_r, writes_nxt;

  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [RND_W-1:0]   rnd_r, rnd_nxt;
  logic [FCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] fr_r, fr_nxt;
  logic [PAGE_W-1:0]  victim_r, victim_nxt;
  logic               wb_pend_r, wb_pend_nxt;
  logic [ACT_W-1:0]   res_act_r, res_act_nxt;
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;

  // least-faults scan pipeline
  logic [NFR_W-1:0]   issue_r, issue_nxt;
  logic               p1_v_r, p1_v_nxt, p2_v_r, p2_v_nxt;
  logic [FRAME_W-1:0] p1_i_r, p1_i_nxt, p2_i_r, p2_i_nxt;
  logic [FRAME_W-1:0] best_r, best_nxt;
  logic [FCNT_W-1:0]  bestv_r, bestv_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]   out_act_r, out_act_nxt;
  logic [PAGE_W-1:0]  out_page_r, out_page_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;
  logic               out_last_r, out_last_nxt;
  logic [TOT_W-1:0]   out_tf_r, out_twf_r, out_tdr_r, out_tdw_r;
  logic               out_load;
  logic               out_free;

  logic [PAGES-1:0]   page_vld_r;
  logic               pvld_q_r;

  logic               page_we;
  logic [PAGE_W-1:0]  page_waddr, page_raddr;
  pte_t               page_wdata, page_rdata, pe;
  logic               owner_we;
  logic [FRAME_W-1:0] owner_waddr, owner_raddr;
  logic [PAGE_W-1:0]  owner_wdata, owner_rdata;

  logic               rem_start;
  rem_stat_t          rem_stat;
  logic [FRAME_W-1:0] rem_val;

  logic [NFR_W-1:0]   fr_free7;
  logic [FRAME_W-1:0] fr_free;
  logic [FCNT_W-1:0]  c1;
  logic               issue;
  logic [FCNT_W-1:0]  scan_v;
  logic [NFR_W-1:0]   cfg_n;
  logic [NFR_W-1:0]   fifo_inc;

  pfr_ram #(.WIDTH(PTE_W), .DEPTH(PAGES)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .raddr (page_raddr),
    .rdata (page_rdata)
  );

  pfr_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_owner_ram (
    .clk   (clk),
    .we    (owner_we),
    .waddr (owner_waddr),
    .wdata (owner_wdata),
    .raddr (owner_raddr),
    .rdata (owner_rdata)
  );

  pfr_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rnd_r),
    .divisor  (frames_r),
    .stat     (rem_stat),
    .rem      (rem_val)
  );

  // entry never written reads as all zero
  assign pe       = pvld_q_r ? page_rdata : '0;
  assign c1       = sat_cnt(pe.cnt);
  assign fr_free7 = frames_r - free_r;
  assign fr_free  = (fr_free7 >= NFR_W'(FRAMES)) ? FRAME_W'(FRAMES - 1) : fr_free7[FRAME_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign fifo_inc = {1'b0, fifo_r} + 1'b1;
  assign scan_v   = pe.cnt;
  assign issue    = issue_r < frames_r;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_n = NFR_W'(1);
    end else if (cfg_data > NFR_W'(FRAMES)) begin
      cfg_n = NFR_W'(FRAMES);
    end else begin
      cfg_n = cfg_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    policy_nxt    = policy_r;
    frames_nxt    = frames_r;
    free_nxt      = free_r;
    fifo_nxt      = fifo_r;
    faults_nxt    = faults_r;
    wfaults_nxt   = wfaults_r;
    reads_nxt     = reads_r;
    writes_nxt    = writes_r;
    page_nxt      = page_r;
    rnd_nxt       = rnd_r;
    cnt_nxt       = cnt_r;
    fr_nxt        = fr_r;
    victim_nxt    = victim_r;
    wb_pend_nxt   = wb_pend_r;
    res_act_nxt   = res_act_r;
    res_frame_nxt = res_frame_r;
    issue_nxt     = issue_r;
    p1_v_nxt      = 1'b0;
    p1_i_nxt      = p1_i_r;
    p2_v_nxt      = 1'b0;
    p2_i_nxt      = p2_i_r;
    best_nxt      = best_r;
    bestv_nxt     = bestv_r;
    out_load      = 1'b0;
    out_act_nxt   = out_act_r;
    out_page_nxt  = out_page_r;
    out_frame_nxt = out_frame_r;
    out_last_nxt  = out_last_r;
    page_raddr    = in_page;
    page_we       = 1'b0;
    page_waddr    = page_r;
    page_wdata    = '0;
    owner_raddr   = fr_r;
    owner_we      = 1'b0;
    owner_waddr   = fr_r;
    owner_wdata   = page_r;
    rem_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          page_nxt  = in_page;
          rnd_nxt   = in_random_pick;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        faults_nxt = sat_tot(faults_r);
        page_we    = 1'b1;
        if (pe.acc == ACC_READ) begin
          // write fault counts twice
          wfaults_nxt   = sat_tot(wfaults_r);
          page_wdata    = '{cnt: sat_cnt(c1), frame: pe.frame, acc: ACC_RW};
          res_act_nxt   = ACT_GRANT;
          res_frame_nxt = pe.frame;
          state_nxt     = S_EMIT_RD;
        end else if (free_r != '0) begin
          owner_we      = 1'b1;
          owner_waddr   = fr_free;
          free_nxt      = free_r - 1'b1;
          reads_nxt     = sat_tot(reads_r);
          page_wdata    = '{cnt: c1, frame: fr_free, acc: ACC_READ};
          res_act_nxt   = ACT_READ;
          res_frame_nxt = fr_free;
          state_nxt     = S_EMIT_RD;
        end else begin
          // count goes in before the victim search sees it
          page_wdata = '{cnt: c1, frame: pe.frame, acc: pe.acc};
          cnt_nxt    = c1;
          case (policy_r)
            POL_RANDOM: begin
              rem_start = 1'b1;
              state_nxt = S_REM;
            end
            POL_LEAST: begin
              issue_nxt = '0;
              state_nxt = S_SCAN;
            end
            default: begin
              fr_nxt    = fifo_r;
              fifo_nxt  = (fifo_inc == frames_r) ? '0 : fifo_inc[FRAME_W-1:0];
              state_nxt = S_OWN;
            end
          endcase
        end
      end
      S_REM: begin
        if (rem_stat.done) begin
          fr_nxt    = rem_val;
          state_nxt = S_OWN;
        end
      end
      S_SCAN: begin
        owner_raddr = issue_r[FRAME_W-1:0];
        page_raddr  = owner_rdata;
        if (issue) begin
          issue_nxt = issue_r + 1'b1;
        end
        p1_v_nxt = issue;
        p1_i_nxt = issue_r[FRAME_W-1:0];
        p2_v_nxt = p1_v_r;
        p2_i_nxt = p1_i_r;
        // first minimum wins
        if (p2_v_r && (p2_i_r == '0 || scan_v < bestv_r)) begin
          best_nxt  = p2_i_r;
          bestv_nxt = scan_v;
        end
        if (!issue && !p1_v_r && !p2_v_r) begin
          fr_nxt    = best_r;
          state_nxt = S_OWN;
        end
      end
      S_OWN: begin
        owner_raddr = fr_r;
        state_nxt   = S_OWN_W;
      end
      S_OWN_W: begin
        victim_nxt = owner_rdata;
        page_raddr = owner_rdata;
        state_nxt  = S_VIC;
      end
      S_VIC: begin
        page_we     = 1'b1;
        page_waddr  = victim_r;
        page_wdata  = '{cnt: pe.cnt, frame: '0, acc: ACC_NONE};
        wb_pend_nxt = (pe.acc == ACC_RW);
        if (pe.acc == ACC_RW) begin
          writes_nxt = sat_tot(writes_r);
        end
        reads_nxt = sat_tot(reads_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // new page written after the victim so that it wins when both are the same
        owner_we      = 1'b1;
        page_we       = 1'b1;
        page_wdata    = '{cnt: cnt_r, frame: fr_r, acc: ACC_READ};
        res_act_nxt   = ACT_READ;
        res_frame_nxt = fr_r;
        state_nxt     = wb_pend_r ? S_EMIT_WB : S_EMIT_RD;
      end
      S_EMIT_WB: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_act_nxt   = ACT_WB;
          out_page_nxt  = victim_r;
          out_frame_nxt = fr_r;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_act_nxt   = res_act_r;
          out_page_nxt  = page_r;
          out_frame_nxt = res_frame_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      if (cfg_index == CFG_POLICY) begin
        policy_nxt = cfg_data[POL_W-1:0];
      end else begin
        frames_nxt = cfg_n;
        free_nxt   = cfg_n;
        fifo_nxt   = '0;
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FIFO;
      frames_r    <= NFR_W'(FRAMES);
      free_r      <= NFR_W'(FRAMES);
      fifo_r      <= '0;
      faults_r    <= '0;
      wfaults_r   <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      page_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      frames_r    <= frames_nxt;
      free_r      <= free_nxt;
      fifo_r      <= fifo_nxt;
      faults_r    <= faults_nxt;
      wfaults_r   <= wfaults_nxt;
      reads_r     <= reads_nxt;
      writes_r    <= writes_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (page_we) begin
        page_vld_r[page_waddr] <= 1'b1;
      end
    end
    pvld_q_r    <= page_vld_r[page_raddr];
    page_r      <= page_nxt;
    rnd_r       <= rnd_nxt;
    cnt_r       <= cnt_nxt;
    fr_r        <= fr_nxt;
    victim_r    <= victim_nxt;
    wb_pend_r   <= wb_pend_nxt;
    res_act_r   <= res_act_nxt;
    res_frame_r <= res_frame_nxt;
    issue_r     <= issue_nxt;
    p1_i_r      <= p1_i_nxt;
    p2_i_r      <= p2_i_nxt;
    best_r      <= best_nxt;
    bestv_r     <= bestv_nxt;
    out_act_r   <= out_act_nxt;
    out_page_r  <= out_page_nxt;
    out_frame_r <= out_frame_nxt;
    out_last_r  <= out_last_nxt;
    if (out_load) begin
      // counters are final for this fault by the time its words go out
      out_tf_r  <= faults_r;
      out_twf_r <= wfaults_r;
      out_tdr_r <= reads_r;
      out_tdw_r <= writes_r;
    end
  end

  assign in_ready               = (state_r == S_IDLE);
  assign out_valid              = out_valid_r;
  assign out_action             = out_act_r;
  assign out_target_page        = out_page_r;
  assign out_target_frame       = out_frame_r;
  assign out_last               = out_last_r;
  assign out_total_faults       = out_tf_r;
  assign out_total_write_faults = out_twf_r;
  assign out_total_disk_reads   = out_tdr_r;
  assign out_total_disk_writes  = out_tdw_r;

`ifndef SYNTHESIS
  a_free_le_frames: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= frames_r) else $error("free frame count above frames in use");

  a_fifo_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, fifo_r} < frames_r) else $error("fifo pointer out of range");

  a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_act_r == ACT_WB |-> !out_last_r)
    else $error("writeback word marked last");

  a_rem_done_in_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_stat.busy || rem_stat.done) |-> state_r == S_REM)
    else $error("remainder unit active outside random pick");

  a_fin_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> state_r == S_EMIT_WB || state_r == S_EMIT_RD)
    else $error("eviction did not proceed to result");
`endif

endmodule
